FILE: rtl/dcrb_pkg.sv
// Package for the delimited command ring buffer.
// Holds command, operation and status codes and the item and result types.
// No dependencies.
`timescale 1ns / 1ps

package dcrb_pkg;

  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_POP     = 2'd1;
  localparam logic [1:0] CMD_DISCARD = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [1:0] OP_BYTE     = 2'd0;
  localparam logic [1:0] OP_END      = 2'd1;
  localparam logic [1:0] OP_POP      = 2'd2;
  localparam logic [1:0] OP_DISCARD  = 2'd3;

  localparam logic [2:0] ST_STAGED   = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_DATA     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic [5:0] MAX_POP     = 6'd32;
  localparam logic [7:0] END_RESET   = 8'd10;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [5:0] limit;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last;
    logic [2:0] status;
    logic       command_waiting;
  } res_t;

endpackage

FILE: rtl/dcrb_if.sv
// Channel interfaces for the delimited command ring buffer.
// Request channel carries commands in, response channel carries results out.
// No dependencies.
`timescale 1ns / 1ps

interface dcrb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] byte_in;
  logic [5:0] read_limit;

  modport source (output valid, command, byte_in, read_limit, input ready);
  modport sink (input valid, command, byte_in, read_limit, output ready);
endinterface

interface dcrb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last;
  logic [2:0] status;
  logic       command_waiting;

  modport source (output valid, byte_out, last, status, command_waiting, input ready);
  modport sink (input valid, byte_out, last, status, command_waiting, output ready);
endinterface

FILE: rtl/delimited_command_ring_buffer.sv
// Top level of the delimited command ring buffer.
// Depends on dcrb_pkg, dcrb_if, dcrb_front, dcrb_back and dcrb_ram.
//
// Commands enter on req (push a byte, pop the oldest command, discard the
// oldest command); results leave on rsp, one transfer per result, with last
// set on the final result of each command. cfg_we writes cfg_wdata into the
// end marker register; write it only while the block is idle.
// A push of an ordinary byte is taken while the output register is free, so
// bytes can stream in at one per cycle; the request is written into the
// queue and its result into the output register. A push of the end marker
// that fits copies the staged command into the ring through the staging
// memory, one byte per cycle, and then loads its result. A pop reads each
// byte from the ring memory and then emits it; a discard reads and checks
// each skipped byte, loading one result at the end marker or an empty ring.
// A two-entry queue in the front end feeds the sequencer. Reset empties the
// ring, the staging buffer and the queue, clears the command count and sets
// the end marker to 10; the memories are not cleared. When the receiver
// stalls, the result is held in the output register, the sequencer waits to
// load its next result, and requests are taken until the queue fills.
`timescale 1ns / 1ps

module delimited_command_ring_buffer #(
  parameter int RING_BYTES    = 64,
  parameter int COMMAND_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  dcrb_req_if.sink   req,
  dcrb_rsp_if.source rsp
);
  import dcrb_pkg::*;

  logic       q_valid;
  logic       q_take;
  item_t      q_item;
  logic [7:0] end_marker;

  dcrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .q_take     (q_take),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .end_marker (end_marker)
  );

  dcrb_back #(
    .RING_BYTES    (RING_BYTES),
    .COMMAND_BYTES (COMMAND_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .end_marker (end_marker),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_take     (q_take),
    .rsp        (rsp)
  );

endmodule

FILE: rtl/dcrb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dcrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dcrb_front.sv
// Front end: holds the end marker register, accepts and classifies requests,
// queues all but CMD_NONE for the back end. Depends on dcrb_pkg and dcrb_if.
`timescale 1ns / 1ps

module dcrb_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  dcrb_req_if.sink       req,
  input  logic           q_take,
  output logic           q_valid,
  output dcrb_pkg::item_t q_item,
  output logic [7:0]     end_marker
);
  import dcrb_pkg::*;

  item_t      qmem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       keep;
  item_t      item;

  always_comb begin
    item.data  = req.byte_in;
    item.limit = req.read_limit;
    if (req.read_limit == 6'd0) begin
      item.limit = 6'd1;
    end else if (req.read_limit > MAX_POP) begin
      item.limit = MAX_POP;
    end
    keep = 1'b1;
    case (req.command)
      CMD_PUSH: item.op = (req.byte_in == end_marker) ? OP_END : OP_BYTE;
      CMD_POP: item.op = OP_POP;
      CMD_DISCARD: item.op = OP_DISCARD;
      default: begin
        item.op = OP_BYTE;
        keep = 1'b0;
      end
    endcase
  end

  assign req.ready = (cnt != 2'd2);
  assign push      = req.valid && req.ready && keep;
  assign q_valid   = (cnt != 2'd0);
  assign q_item    = qmem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker <= END_RESET;
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (cfg_we) begin
        end_marker <= cfg_wdata;
      end
      if (push) begin
        wp <= ~wp;
      end
      if (q_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, q_take};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp] <= item;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("Queue count exceeds its depth.");
  assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("Back end took an item from an empty queue.");
  assert property (@(posedge clk) disable iff (rst) (q_valid && !q_take) |=> $stable(q_item))
    else $error("Queued item changed while it waited.");
`endif

endmodule

FILE: rtl/dcrb_back.sv
// Back end: staging store, command ring and the sequencer that carries out
// pushes, commits, pops and discards, plus the output register.
// Depends on dcrb_pkg, dcrb_if and dcrb_ram.
`timescale 1ns / 1ps

module dcrb_back #(
  parameter int RING_BYTES    = 64,
  parameter int COMMAND_BYTES = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      end_marker,
  input  logic            q_valid,
  input  dcrb_pkg::item_t q_item,
  output logic            q_take,
  dcrb_rsp_if.source      rsp
);
  import dcrb_pkg::*;

  localparam int PW = $clog2(RING_BYTES);
  localparam int SW = $clog2(COMMAND_BYTES);
  localparam int LW = $clog2(COMMAND_BYTES + 1);
  localparam int UW = $clog2(RING_BYTES + COMMAND_BYTES + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_COPY     = 3'd1;
  localparam logic [2:0] S_COMMIT   = 3'd2;
  localparam logic [2:0] S_POP_RD   = 3'd3;
  localparam logic [2:0] S_POP_EMIT = 3'd4;
  localparam logic [2:0] S_DISC_RD  = 3'd5;
  localparam logic [2:0] S_DISC_CHK = 3'd6;

  logic [2:0]    state, state_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] cmd_count, cmd_count_next;
  logic [LW-1:0] stg_len, stg_len_next;
  logic [LW-1:0] cp_len, cp_len_next;
  logic [LW-1:0] cp_issue, cp_issue_next;
  logic          cp_pend, cp_pend_next;
  logic [5:0]    lim, lim_next;
  logic [5:0]    k, k_next;

  logic          out_valid;
  res_t          out_data;
  logic          out_free;
  logic          emit;
  res_t          res;

  logic          stg_we;
  logic [SW-1:0] stg_waddr;
  logic          stg_re;
  logic [SW-1:0] stg_raddr;
  logic [7:0]    stg_rdata;
  logic          ring_we;
  logic          ring_re;
  logic [7:0]    ring_rdata;

  logic [SW-1:0] stg_idx;
  logic [LW-1:0] new_len;
  logic [PW-1:0] used;
  logic          fits;
  logic          empty;
  logic [PW-1:0] rd_inc;
  logic [PW-1:0] wr_inc;
  logic [PW-1:0] cnt_take;
  logic          pop_stop;
  logic          disc_stop;

  dcrb_ram #(.WIDTH(8), .DEPTH(COMMAND_BYTES)) u_stg (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (q_item.data),
    .re    (stg_re),
    .raddr (stg_raddr),
    .rdata (stg_rdata)
  );

  dcrb_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wr_ptr),
    .wdata (stg_rdata),
    .re    (ring_re),
    .raddr (rd_ptr),
    .rdata (ring_rdata)
  );

  assign out_free  = !out_valid || rsp.ready;
  assign empty     = (rd_ptr == wr_ptr);
  assign rd_inc    = (rd_ptr == PW'(RING_BYTES - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_inc    = (wr_ptr == PW'(RING_BYTES - 1)) ? '0 : wr_ptr + 1'b1;
  assign used      = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr
                                        : PW'(RING_BYTES) + wr_ptr - rd_ptr;
  assign stg_idx   = (stg_len >= LW'(COMMAND_BYTES)) ? '0 : stg_len[SW-1:0];
  assign new_len   = LW'(stg_idx) + 1'b1;
  assign fits      = (UW'(new_len) + UW'(used)) <= UW'(RING_BYTES - 1);

  always_comb begin
    cnt_take = cmd_count;
    if ((ring_rdata == end_marker) && (cmd_count != '0)) begin
      cnt_take = cmd_count - 1'b1;
    end
    if (rd_inc == wr_ptr) begin
      cnt_take = '0;
    end
  end

  assign pop_stop  = (ring_rdata == end_marker) || ((k + 6'd1) == lim) || (rd_inc == wr_ptr);
  assign disc_stop = (ring_rdata == end_marker) || (rd_inc == wr_ptr);

  always_comb begin
    state_next     = state;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    cmd_count_next = cmd_count;
    stg_len_next   = stg_len;
    cp_len_next    = cp_len;
    cp_issue_next  = cp_issue;
    cp_pend_next   = 1'b0;
    lim_next       = lim;
    k_next         = k;
    q_take         = 1'b0;
    emit           = 1'b0;
    res            = '0;
    res.last       = 1'b1;
    stg_we         = 1'b0;
    stg_waddr      = stg_idx;
    stg_re         = 1'b0;
    stg_raddr      = cp_issue[SW-1:0];
    ring_we        = 1'b0;
    ring_re        = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_BYTE: begin
              if (out_free) begin
                q_take       = 1'b1;
                stg_we       = 1'b1;
                stg_len_next = new_len;
                emit         = 1'b1;
                res.status   = ST_STAGED;
                res.command_waiting = (cmd_count != '0);
              end
            end
            OP_END: begin
              if (fits) begin
                q_take        = 1'b1;
                stg_we        = 1'b1;
                cp_len_next   = new_len;
                cp_issue_next = '0;
                state_next    = S_COPY;
              end else if (out_free) begin
                q_take       = 1'b1;
                stg_len_next = '0;
                emit         = 1'b1;
                res.status   = ST_DROPPED;
                res.command_waiting = (cmd_count != '0);
              end
            end
            OP_POP, OP_DISCARD: begin
              if (empty) begin
                if (out_free) begin
                  q_take     = 1'b1;
                  emit       = 1'b1;
                  res.status = ST_EMPTY;
                  res.command_waiting = (cmd_count != '0);
                end
              end else begin
                q_take     = 1'b1;
                lim_next   = q_item.limit;
                k_next     = 6'd0;
                state_next = (q_item.op == OP_POP) ? S_POP_RD : S_DISC_RD;
              end
            end
            default: begin
              q_take = 1'b1;
            end
          endcase
        end
      end
      S_COPY: begin
        if (cp_issue != cp_len) begin
          stg_re        = 1'b1;
          cp_issue_next = cp_issue + 1'b1;
          cp_pend_next  = 1'b1;
        end
        if (cp_pend) begin
          ring_we     = 1'b1;
          wr_ptr_next = wr_inc;
        end
        if ((cp_issue == cp_len) && !cp_pend) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_count_next = cmd_count + 1'b1;
          stg_len_next   = '0;
          emit           = 1'b1;
          res.status     = ST_STORED;
          res.command_waiting = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_POP_RD: begin
        ring_re    = 1'b1;
        state_next = S_POP_EMIT;
      end
      S_POP_EMIT: begin
        if (out_free) begin
          rd_ptr_next    = rd_inc;
          cmd_count_next = cnt_take;
          emit           = 1'b1;
          res.byte_out   = ring_rdata;
          res.last       = pop_stop;
          res.status     = ST_DATA;
          res.command_waiting = (cnt_take != '0);
          k_next         = k + 6'd1;
          state_next     = pop_stop ? S_IDLE : S_POP_RD;
        end
      end
      S_DISC_RD: begin
        ring_re    = 1'b1;
        state_next = S_DISC_CHK;
      end
      S_DISC_CHK: begin
        if (!disc_stop) begin
          rd_ptr_next    = rd_inc;
          cmd_count_next = cnt_take;
          state_next     = S_DISC_RD;
        end else if (out_free) begin
          rd_ptr_next    = rd_inc;
          cmd_count_next = cnt_take;
          emit           = 1'b1;
          res.status     = ST_DATA;
          res.command_waiting = (cnt_take != '0);
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      cmd_count <= '0;
      stg_len   <= '0;
      cp_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      cmd_count <= cmd_count_next;
      stg_len   <= stg_len_next;
      cp_pend   <= cp_pend_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_len   <= cp_len_next;
    cp_issue <= cp_issue_next;
    lim      <= lim_next;
    k        <= k_next;
    if (emit) begin
      out_data <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.byte_out        = out_data.byte_out;
  assign rsp.last            = out_data.last;
  assign rsp.status          = out_data.status;
  assign rsp.command_waiting = out_data.command_waiting;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) (rd_ptr == wr_ptr) |-> (cmd_count == '0))
    else $error("Command count is nonzero while the ring is empty.");
  assert property (@(posedge clk) disable iff (rst) stg_len <= LW'(COMMAND_BYTES))
    else $error("Staging length exceeds the staging store.");
  assert property (@(posedge clk) disable iff (rst) emit |-> out_free)
    else $error("Result loaded while the output register still holds one.");
  assert property (@(posedge clk) disable iff (rst)
      (state == S_COPY) |=> (state == S_COPY) || (state == S_COMMIT))
    else $error("Commit copy left before its result was issued.");
`endif

endmodule

FILE: tb/delimited_command_ring_buffer_tb.sv
// Self-checking testbench for delimited_command_ring_buffer.
// Random and directed command streams are checked against a built-in ring model.
// Depends on dcrb_pkg, dcrb_if and the RTL of the block.
`timescale 1ns / 1ps

module delimited_command_ring_buffer_tb;
  import dcrb_pkg::*;

  localparam int RING_SIZE     = 64;
  localparam int STAGE_SIZE    = 32;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 1000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       send_valid = 1'b0;
  item_t      send_item = '0;
  logic       recv_ready = 1'b0;
  logic       hold_off = 1'b0;
  logic       quiet = 1'b0;

  int send_gap = 0;
  int recv_gap = 0;
  int accepted_count = 0;
  int cycle_count = 0;
  int error_count = 0;

  item_t commands_to_send[$];
  res_t  replies_due[$];

  logic [7:0] ring_mem [RING_SIZE];
  logic [7:0] stage_mem [STAGE_SIZE];
  logic [5:0] rd_ptr = '0;
  logic [5:0] wr_ptr = '0;
  int         held_commands = 0;
  int         staged_count = 0;
  logic [7:0] end_code = END_RESET;

  dcrb_req_if req_ch ();
  dcrb_rsp_if rsp_ch ();

  assign req_ch.valid      = send_valid;
  assign req_ch.command    = send_item.op;
  assign req_ch.byte_in    = send_item.data;
  assign req_ch.read_limit = send_item.limit;
  assign rsp_ch.ready      = recv_ready;

  delimited_command_ring_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_reply(input logic [7:0] value, input logic fin, input logic [2:0] code);
    res_t r;
    r.byte_out = value;
    r.last = fin;
    r.status = code;
    r.command_waiting = held_commands != 0;
    replies_due.push_back(r);
  endtask

  task automatic take_ring_byte(output logic [7:0] value);
    value = ring_mem[rd_ptr];
    rd_ptr = rd_ptr + 6'd1;
    if (value == end_code && held_commands != 0) held_commands--;
    if (rd_ptr == wr_ptr) held_commands = 0;
  endtask

  task automatic apply_command(input item_t it);
    logic [5:0] used;
    logic [7:0] b;
    logic       stop;
    int         lim;
    case (it.op)
      CMD_PUSH: begin
        if (staged_count >= STAGE_SIZE) staged_count = 0;
        stage_mem[staged_count[4:0]] = it.data;
        staged_count++;
        used = wr_ptr - rd_ptr;
        if (it.data != end_code) begin
          add_reply(8'h00, 1'b1, ST_STAGED);
        end else if (staged_count + int'(used) <= RING_SIZE - 1) begin
          for (int i = 0; i < staged_count; i++) begin
            ring_mem[wr_ptr] = stage_mem[i[4:0]];
            wr_ptr = wr_ptr + 6'd1;
          end
          held_commands++;
          staged_count = 0;
          add_reply(8'h00, 1'b1, ST_STORED);
        end else begin
          staged_count = 0;
          add_reply(8'h00, 1'b1, ST_DROPPED);
        end
      end
      CMD_POP: begin
        if (rd_ptr == wr_ptr) begin
          add_reply(8'h00, 1'b1, ST_EMPTY);
        end else begin
          lim = int'(it.limit);
          if (lim == 0) lim = 1;
          if (lim > int'(MAX_POP)) lim = int'(MAX_POP);
          for (int k = 0; k < lim; k++) begin
            take_ring_byte(b);
            stop = (b == end_code) || (k + 1 == lim) || (rd_ptr == wr_ptr);
            add_reply(b, stop, ST_DATA);
            if (stop) break;
          end
        end
      end
      CMD_DISCARD: begin
        if (rd_ptr == wr_ptr) begin
          add_reply(8'h00, 1'b1, ST_EMPTY);
        end else begin
          stop = 1'b0;
          while (rd_ptr != wr_ptr && !stop) begin
            take_ring_byte(b);
            stop = (b == end_code);
          end
          add_reply(8'h00, 1'b1, ST_DATA);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    if (error_count < 40) $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin : driver
    item_t nxt;
    if (!rst) begin
      if (send_valid && req_ch.ready === 1'b1) begin
        apply_command(send_item);
        accepted_count <= accepted_count + 1;
      end
      if (!send_valid || req_ch.ready === 1'b1) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          send_valid <= 1'b0;
        end else if (commands_to_send.size() != 0) begin
          nxt = commands_to_send.pop_front();
          send_item <= nxt;
          send_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (!rst) begin
      if (rsp_ch.valid === 1'b1 && recv_ready) begin
        got.byte_out = rsp_ch.byte_out;
        got.last = rsp_ch.last;
        got.status = rsp_ch.status;
        got.command_waiting = rsp_ch.command_waiting;
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = replies_due.pop_front();
          if (got.byte_out !== want.byte_out)
            report_mismatch($sformatf("byte_out %02h, expected %02h",
                                      got.byte_out, want.byte_out));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.command_waiting !== want.command_waiting)
            report_mismatch($sformatf("command_waiting %b, expected %b",
                                      got.command_waiting, want.command_waiting));
        end
      end
      if (hold_off) begin
        recv_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        recv_ready <= 1'b0;
      end else begin
        recv_ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : back_pressure
    while (accepted_count < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic queue_item(input logic [1:0] op, input logic [7:0] data,
                            input logic [5:0] limit);
    item_t it;
    it.op = op;
    it.data = data;
    it.limit = limit;
    commands_to_send.push_back(it);
  endtask

  task automatic queue_plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == end_code);
    queue_item(CMD_PUSH, b, 6'($urandom_range(0, 63)));
  endtask

  task automatic queue_random_traffic(input int target, input int pop_pct);
    int counted;
    int r;
    int body;
    int sel;
    counted = 0;
    while (counted < target) begin
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
        if ($urandom_range(0, 4) == 0)
          queue_item(CMD_POP, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        else
          queue_item(CMD_POP, 8'($urandom_range(0, 255)), 6'($urandom_range(1, 32)));
        counted++;
      end else if (r < pop_pct + 10) begin
        queue_item(CMD_DISCARD, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        counted++;
      end else if (r < pop_pct + 14) begin
        queue_item(CMD_NONE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
      end else if (r < pop_pct + 22) begin
        queue_item(CMD_PUSH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        counted++;
      end else if (r < pop_pct + 28) begin
        body = $urandom_range(1, 6);
        repeat (body) queue_plain_byte();
        counted += body;
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 14) body = $urandom_range(0, 10);
        else if (sel < 18) body = $urandom_range(11, 31);
        else body = $urandom_range(32, 40);
        repeat (body) queue_plain_byte();
        queue_item(CMD_PUSH, end_code, 6'($urandom_range(0, 63)));
        counted += body + 1;
      end
    end
  endtask

  task automatic wait_idle();
    while (commands_to_send.size() != 0 || send_valid || replies_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_end_marker(input logic [7:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    end_code = value;
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_item(CMD_POP, 8'h00, 6'd1);
    queue_item(CMD_DISCARD, 8'hFF, 6'd0);
    queue_item(CMD_NONE, 8'h5A, 6'd63);
    queue_item(CMD_PUSH, 8'hFF, 6'd0);
    queue_item(CMD_PUSH, 8'h00, 6'd63);
    queue_item(CMD_PUSH, END_RESET, 6'd1);
    queue_item(CMD_PUSH, 8'hAA, 6'd32);
    queue_item(CMD_PUSH, END_RESET, 6'd33);
    queue_item(CMD_POP, 8'hFF, 6'd0);
    queue_item(CMD_POP, 8'h00, 6'd63);
    queue_item(CMD_DISCARD, 8'h00, 6'd1);
    queue_item(CMD_DISCARD, 8'h00, 6'd1);
    queue_item(CMD_PUSH, 8'h55, 6'd1);
    queue_item(CMD_POP, 8'h00, 6'd32);
    queue_item(CMD_PUSH, END_RESET, 6'd1);
    queue_item(CMD_PUSH, 8'h81, 6'd1);
    queue_item(CMD_PUSH, END_RESET, 6'd1);
    queue_item(CMD_POP, 8'h00, 6'd1);
    queue_item(CMD_POP, 8'h00, 6'd32);
    queue_item(CMD_POP, 8'h00, 6'd2);
    queue_item(CMD_POP, 8'h00, 6'd2);

    set_end_marker(8'h00);
    queue_random_traffic(45, 12);

    set_end_marker(8'hFF);
    quiet <= 1'b1;
    queue_random_traffic(45, 40);

    set_end_marker(8'($urandom_range(1, 254)));
    quiet <= 1'b0;
    queue_random_traffic(50, 28);

    set_end_marker(END_RESET);
    queue_random_traffic(50, 35);

    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: delimited_command_ring_buffer.f
rtl/dcrb_pkg.sv
rtl/dcrb_if.sv
rtl/dcrb_ram.sv
rtl/dcrb_front.sv
rtl/dcrb_back.sv
rtl/delimited_command_ring_buffer.sv
tb/delimited_command_ring_buffer_tb.sv
